### sv/slac_pkg.sv
// ----------------------------------------------------------------------------
// slac_pkg
// Shared types, constants and helpers of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`default_nettype none

package slac_pkg;

	// default geometry
	localparam int DEF_NUM_SETS    = 64;
	localparam int DEF_NUM_WAYS    = 4;
	localparam int DEF_BLOCK_BYTES = 16;

	// fixed field widths
	localparam int ADDR_W     = 32;
	localparam int CNT_W      = 32;
	localparam int STAMP_W    = 32;
	localparam int CYC_W      = 48;
	localparam int WAY_USED_W = 2;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HIT_CYCLES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISS_CYCLES = 1'd1;

	localparam logic [CFG_DATA_W-1:0] HIT_CYCLES_RST  = 16'd1;
	localparam logic [CFG_DATA_W-1:0] MISS_CYCLES_RST = 16'd100;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic lookup;
		logic mult;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} stat_t;

	// floor of log2, used on parameters only
	function automatic int flog2(input int v);
		int n;
		int x;
		n = 0;
		x = v;
		while (x > 1) begin
			x = x >> 1;
			n++;
		end
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

### sv/slac_if.sv
// ----------------------------------------------------------------------------
// slac_if
// Valid/ready channels: address in, lookup result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface slac_access_if;
	import slac_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

interface slac_result_if;
	import slac_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic                  evicted;
	logic [WAY_USED_W-1:0] way_used;
	logic [CNT_W-1:0]      hit_total;
	logic [CNT_W-1:0]      miss_total;
	logic [CNT_W-1:0]      evict_total;
	logic [CYC_W-1:0]      cycle_total;

	modport source (output valid, output hit, output evicted, output way_used,
		output hit_total, output miss_total, output evict_total, output cycle_total,
		input ready);
	modport sink (input valid, input hit, input evicted, input way_used,
		input hit_total, input miss_total, input evict_total, input cycle_total,
		output ready);
endinterface

`default_nettype wire

### sv/slac_ctrl.sv
// ----------------------------------------------------------------------------
// slac_ctrl
// Sequencer: tag store clearing pass, then read / lookup / multiply / sum.
// ----------------------------------------------------------------------------
`default_nettype none

module slac_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire slac_pkg::stat_t stat,
	output slac_pkg::cmd_t      cmd
);
	import slac_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_SUM   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mult = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				// wait here until the output register can take the transaction
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_look_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOK |-> $past(state_q) == ST_IDLE)
		else $error("lookup not preceded by an accepted transaction");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("output register overwritten");

	a_clear_runs_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR && !stat.clr_last |=> state_q == ST_CLEAR)
		else $error("clearing pass cut short");

endmodule

`default_nettype wire

### sv/slac_dp.sv
// ----------------------------------------------------------------------------
// slac_dp
// Set store, tag match and LRU victim tree, totals, cost multiply, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module slac_dp #(
	parameter int NUM_SETS    = slac_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS    = slac_pkg::DEF_NUM_WAYS,
	parameter int BLOCK_BYTES = slac_pkg::DEF_BLOCK_BYTES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire slac_pkg::cmd_t                    cmd,
	output slac_pkg::stat_t                        stat,
	input  wire logic                              cfg_we,
	input  wire logic [slac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [slac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic [slac_pkg::ADDR_W-1:0]       in_address,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic                                   out_hit,
	output logic                                   out_evicted,
	output logic [slac_pkg::WAY_USED_W-1:0]        out_way_used,
	output logic [slac_pkg::CNT_W-1:0]             out_hit_total,
	output logic [slac_pkg::CNT_W-1:0]             out_miss_total,
	output logic [slac_pkg::CNT_W-1:0]             out_evict_total,
	output logic [slac_pkg::CYC_W-1:0]             out_cycle_total
);
	import slac_pkg::*;

	localparam int OFF_BITS = flog2(BLOCK_BYTES);
	localparam int SET_BITS = flog2(NUM_SETS);
	localparam int ROWS     = 1 << SET_BITS;
	localparam int SIW      = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W    = ADDR_W - OFF_BITS - SET_BITS;
	localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int P        = 1 << $clog2(NUM_WAYS);
	localparam int NODES    = 2 * P - 1;
	localparam logic [ADDR_W-1:0] SET_MASK = (ADDR_W'(1) << SET_BITS) - ADDR_W'(1);

	// set store, one row per set
	logic [NUM_WAYS-1:0]                    mem_valid [ROWS];
	logic [NUM_WAYS-1:0][TAG_W-1:0]         mem_tag   [ROWS];
	logic [NUM_WAYS-1:0][STAMP_W-1:0]       mem_stamp [ROWS];

	logic [NUM_WAYS-1:0]                    rd_valid_q;
	logic [NUM_WAYS-1:0][TAG_W-1:0]         rd_tag_q;
	logic [NUM_WAYS-1:0][STAMP_W-1:0]       rd_stamp_q;

	logic [NUM_WAYS-1:0]                    wr_valid;
	logic [NUM_WAYS-1:0][TAG_W-1:0]         wr_tag;
	logic [NUM_WAYS-1:0][STAMP_W-1:0]       wr_stamp;
	logic                                   wr_en;
	logic [SIW-1:0]                         wr_addr;

	logic [ADDR_W-1:0]     addr_q;
	logic [SIW-1:0]        in_set;
	logic [SIW-1:0]        q_set;
	logic [TAG_W-1:0]      q_tag;
	logic [SIW-1:0]        clr_q;

	logic [CFG_DATA_W-1:0] hit_cycles_q;
	logic [CFG_DATA_W-1:0] miss_cycles_q;

	logic [STAMP_W-1:0]    stamp_q;
	logic [CNT_W-1:0]      hits_q;
	logic [CNT_W-1:0]      misses_q;
	logic [CNT_W-1:0]      evicts_q;

	logic                  hit_q;
	logic                  evict_q;
	logic [WAY_W-1:0]      way_q;

	logic [CYC_W-1:0]      prod_h_q;
	logic [CYC_W-1:0]      prod_m_q;
	logic [CYC_W:0]        cyc_sum;
	logic [CYC_W-1:0]      cyc_sat;

	logic [NUM_WAYS-1:0]   match;
	logic                  lk_hit;
	logic                  lk_full;
	logic                  lk_evict;
	logic [WAY_W-1:0]      hit_way;
	logic [WAY_W-1:0]      empty_way;
	logic [WAY_W-1:0]      lk_way;

	logic                  out_valid_q;

	// address split
	assign in_set = SIW'((in_address >> OFF_BITS) & SET_MASK);
	assign q_set  = SIW'((addr_q >> OFF_BITS) & SET_MASK);
	assign q_tag  = TAG_W'(addr_q >> (OFF_BITS + SET_BITS));

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cycles_q  <= HIT_CYCLES_RST;
			miss_cycles_q <= MISS_CYCLES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HIT_CYCLES:  hit_cycles_q  <= cfg_wdata;
				REG_MISS_CYCLES: miss_cycles_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + SIW'(1);
		end
	end

	assign stat.clr_last = (clr_q == SIW'(ROWS - 1));

	// tag match, first hit and first empty way
	always_comb begin
		hit_way   = '0;
		empty_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			match[w] = rd_valid_q[w] && (rd_tag_q[w] == q_tag);
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (!rd_valid_q[w]) begin
				empty_way = WAY_W'(w);
			end
		end
	end

	// oldest stamp among valid ways, ties to the lower way
	logic [STAMP_W-1:0] nd_key [NODES];
	logic [WAY_W-1:0]   nd_idx [NODES];
	logic               nd_ok  [NODES];

	for (genvar n = 0; n < NODES; n++) begin : g_node
		if (n >= P - 1) begin : g_leaf
			if (n - (P - 1) < NUM_WAYS) begin : g_way
				assign nd_ok[n]  = rd_valid_q[n-(P-1)];
				assign nd_key[n] = rd_stamp_q[n-(P-1)];
				assign nd_idx[n] = WAY_W'(n - (P - 1));
			end else begin : g_pad
				assign nd_ok[n]  = 1'b0;
				assign nd_key[n] = '0;
				assign nd_idx[n] = '0;
			end
		end else begin : g_cmp
			logic take_l;
			assign take_l = nd_ok[2*n+1] &&
				(!nd_ok[2*n+2] || (nd_key[2*n+1] <= nd_key[2*n+2]));
			assign nd_ok[n]  = nd_ok[2*n+1] || nd_ok[2*n+2];
			assign nd_key[n] = take_l ? nd_key[2*n+1] : nd_key[2*n+2];
			assign nd_idx[n] = take_l ? nd_idx[2*n+1] : nd_idx[2*n+2];
		end
	end

	assign lk_hit   = |match;
	assign lk_full  = &rd_valid_q;
	assign lk_evict = !lk_hit && lk_full;
	assign lk_way   = lk_hit ? hit_way : (lk_full ? nd_idx[0] : empty_way);

	// write-back row
	always_comb begin
		wr_en    = cmd.clear || cmd.lookup;
		wr_addr  = cmd.clear ? clr_q : q_set;
		wr_valid = rd_valid_q;
		wr_tag   = rd_tag_q;
		wr_stamp = rd_stamp_q;
		wr_valid[lk_way] = 1'b1;
		wr_stamp[lk_way] = stamp_q;
		if (!lk_hit) begin
			wr_tag[lk_way] = q_tag;
		end
		if (cmd.clear) begin
			wr_valid = '0;
			wr_tag   = '0;
			wr_stamp = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_valid[wr_addr] <= wr_valid;
			mem_tag[wr_addr]   <= wr_tag;
			mem_stamp[wr_addr] <= wr_stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q     <= in_address;
			rd_valid_q <= mem_valid[in_set];
			rd_tag_q   <= mem_tag[in_set];
			rd_stamp_q <= mem_stamp[in_set];
		end
	end

	// running totals and stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q  <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else if (cmd.lookup) begin
			stamp_q <= stamp_q + STAMP_W'(1);
			if (lk_hit) begin
				hits_q <= sat_inc(hits_q);
			end else begin
				misses_q <= sat_inc(misses_q);
			end
			if (lk_evict) begin
				evicts_q <= sat_inc(evicts_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_q   <= lk_hit;
			evict_q <= lk_evict;
			way_q   <= lk_way;
		end
		if (cmd.mult) begin
			prod_h_q <= CYC_W'(hits_q) * CYC_W'(hit_cycles_q);
			prod_m_q <= CYC_W'(misses_q) * CYC_W'(miss_cycles_q);
		end
	end

	assign cyc_sum = {1'b0, prod_m_q} + {1'b0, prod_h_q};
	assign cyc_sat = cyc_sum[CYC_W] ? '1 : cyc_sum[CYC_W-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hit         <= hit_q;
			out_evicted     <= evict_q;
			out_way_used    <= WAY_USED_W'(way_q);
			out_hit_total   <= hits_q;
			out_miss_total  <= misses_q;
			out_evict_total <= evicts_q;
			out_cycle_total <= cyc_sat;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || out_ready;

	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |=> stamp_q == $past(stamp_q) + STAMP_W'(1))
		else $error("stamp counter did not advance by one");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup && lk_hit && hits_q != '1 |=> hits_q == $past(hits_q) + CNT_W'(1))
		else $error("hit total missed an increment");

	a_miss_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.lookup |=> $stable(misses_q))
		else $error("miss total moved outside a lookup");

endmodule

`default_nettype wire

### sv/set_assoc_lru_cache_model_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_unit
// Set-associative cache model with LRU replacement and cost accounting.
// Steps: set read at acceptance, lookup and write-back, cost multiply, sum,
// then the output register; a new address is accepted only after the sum
// step has loaded the result. A held result stalls only the sum step.
// Reset: a clearing pass over every set row runs with ready low;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_model_unit #(
	parameter int NUM_SETS    = slac_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS    = slac_pkg::DEF_NUM_WAYS,
	parameter int BLOCK_BYTES = slac_pkg::DEF_BLOCK_BYTES
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [slac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [slac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	slac_access_if.sink                          access,
	slac_result_if.source                        result
);
	import slac_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	slac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (access.valid),
		.in_ready (access.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	slac_dp #(
		.NUM_SETS    (NUM_SETS),
		.NUM_WAYS    (NUM_WAYS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_address      (access.address),
		.out_ready       (result.ready),
		.out_valid       (result.valid),
		.out_hit         (result.hit),
		.out_evicted     (result.evicted),
		.out_way_used    (result.way_used),
		.out_hit_total   (result.hit_total),
		.out_miss_total  (result.miss_total),
		.out_evict_total (result.evict_total),
		.out_cycle_total (result.cycle_total)
	);

endmodule

`default_nettype wire
